// ===== hdl/counting_multiset_min_max_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the counting multiset core
// Concurrent checks under the core clock, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef COUNTING_MULTISET_MIN_MAX_CORE_MACROS_SVH
`define COUNTING_MULTISET_MIN_MAX_CORE_MACROS_SVH

// Same-cycle implication: when a holds, b must hold.
`define CMMM_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("counting multiset check failed: same-cycle implication");

// Next-cycle implication: when a holds, b must hold in the following cycle.
`define CMMM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("counting multiset check failed: next-cycle implication");

`endif

// ===== hdl/cmmm_pkg.sv =====
// ----------------------------------------------------------------------------
// cmmm_pkg
// Shared widths, register indexes and fault codes of the counting multiset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmmm_pkg;

    // Width of values and range registers.
    localparam int VALUE_W = 16;
    // Signed width wide enough for base plus store span.
    localparam int SUM_W = 18;
    // Configuration register index width.
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_HIGH = 1'd1;

    typedef enum logic [1:0] {
        FAULT_OK     = 2'd0,
        FAULT_RANGE  = 2'd1,
        FAULT_ABSENT = 2'd2,
        FAULT_FULL   = 2'd3
    } t_fault;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

endpackage

// ===== hdl/cmmm_count_ram.sv =====
// ----------------------------------------------------------------------------
// cmmm_count_ram
// Per-value count store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmmm_count_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cmmm_range_check.sv =====
// ----------------------------------------------------------------------------
// cmmm_range_check
// Range test of a value against the clipped window and its store index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmmm_range_check
    import cmmm_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic signed [VALUE_W-1:0] i_range_low,
    input  logic signed [VALUE_W-1:0] i_range_high,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_in_range,
    output logic [$clog2(DEPTH)-1:0]  o_index
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic signed [SUM_W-1:0] SPAN = SUM_W'(DEPTH - 1);

    logic signed [SUM_W-1:0] w_x;
    logic signed [SUM_W-1:0] w_lo;
    logic signed [SUM_W-1:0] w_hi;
    logic signed [SUM_W-1:0] w_lim;
    logic signed [SUM_W-1:0] w_diff;

    assign w_x    = SUM_W'(i_value);
    assign w_lo   = SUM_W'(i_range_low);
    assign w_hi   = SUM_W'(i_range_high);
    assign w_lim  = w_lo + SPAN;
    assign w_diff = w_x - w_lo;

    // Clip the top of the window to the store span.
    assign o_in_range = (w_x >= w_lo) && (w_x <= w_hi) && (w_x <= w_lim);
    assign o_index    = w_diff[ADDR_W-1:0];

endmodule

// ===== hdl/counting_multiset_min_max_core.sv =====
// ----------------------------------------------------------------------------
// counting_multiset_min_max_core
// Multiset of bounded signed values with running lowest and highest value.
// ----------------------------------------------------------------------------
// Each input beat inserts or removes one copy of a value; each one yields
// exactly one result beat with the lowest and highest value present, an
// empty flag and a fault code, unless a register write cuts it off. An
// out-of-range item goes from acceptance straight to the result load; an
// in-range item passes through accept with count read, count update and
// result load. Removing the last copy of the current lowest or highest
// value while other values remain adds a scan of the count store, one
// entry per cycle, over the entries between the removed value and the
// next occupied one. The registered read of the count store sets these
// steps. After reset and after every register write the store is cleared
// by a pass over all DEPTH entries, during which no input beat is taken
// (register writes still are, and restart it). A finished result waits in
// the output register while the next item is already accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "counting_multiset_min_max_core_macros.svh"

module counting_multiset_min_max_core
    import cmmm_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [VALUE_W-1:0]        i_cfg_data,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_operation,
    input  logic signed [VALUE_W-1:0] i_item_value,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_low_value,
    output logic signed [VALUE_W-1:0] o_high_value,
    output logic                      o_set_empty,
    output logic [1:0]                o_fault
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int TOTAL_W = ADDR_W + COUNT_WIDTH;
    localparam logic [ADDR_W-1:0]      LAST_IDX  = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
    localparam logic [TOTAL_W-1:0]     TOTAL_ONE = TOTAL_W'(1);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_UPDATE  = 6'b000100,
        ST_SCAN_UP = 6'b001000,
        ST_SCAN_DN = 6'b010000,
        ST_FINISH  = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [ADDR_W-1:0]         r_clr_ptr, n_clr_ptr;
    logic signed [VALUE_W-1:0] r_range_low, n_range_low;
    logic signed [VALUE_W-1:0] r_range_high, n_range_high;
    logic [ADDR_W-1:0]         r_lo, n_lo;
    logic [ADDR_W-1:0]         r_hi, n_hi;
    logic [TOTAL_W-1:0]        r_total, n_total;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic [ADDR_W-1:0]         r_ptr, n_ptr;
    t_op                       r_op, n_op;
    t_fault                    r_fault, n_fault;

    logic                      r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_out_low, n_out_low;
    logic signed [VALUE_W-1:0] r_out_high, n_out_high;
    logic                      r_out_empty, n_out_empty;
    t_fault                    r_out_fault, n_out_fault;

    logic                      w_in_range;
    logic [ADDR_W-1:0]         w_in_idx;
    logic                      w_in_accept;
    logic                      w_out_free;

    logic                      w_mem_we;
    logic [ADDR_W-1:0]         w_mem_waddr;
    logic [COUNT_WIDTH-1:0]    w_mem_wdata;
    logic [ADDR_W-1:0]         w_mem_raddr;
    logic [COUNT_WIDTH-1:0]    w_mem_rdata;

    cmmm_range_check #(
        .DEPTH (DEPTH)
    ) u_range (
        .i_range_low  (r_range_low),
        .i_range_high (r_range_high),
        .i_value      (i_item_value),
        .o_in_range   (w_in_range),
        .o_index      (w_in_idx)
    );

    cmmm_count_ram #(
        .DEPTH (DEPTH),
        .WIDTH (COUNT_WIDTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Take a beat only while idle; the clearing pass and the update steps stall.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);
    // Output register can be loaded when empty or being drained this cycle.
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_clr_ptr    = r_clr_ptr;
        n_range_low  = r_range_low;
        n_range_high = r_range_high;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_total      = r_total;
        n_idx        = r_idx;
        n_ptr        = r_ptr;
        n_op         = r_op;
        n_fault      = r_fault;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_low    = r_out_low;
        n_out_high   = r_out_high;
        n_out_empty  = r_out_empty;
        n_out_fault  = r_out_fault;

        w_mem_we     = 1'b0;
        w_mem_waddr  = r_idx;
        w_mem_wdata  = w_mem_rdata;
        w_mem_raddr  = r_idx;

        case (r_state)
            ST_CLEAR: begin
                // Zero one count entry per cycle.
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_ptr;
                w_mem_wdata = '0;
                if (r_clr_ptr == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_ptr = r_clr_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                // Fetch the count of the incoming value right away.
                w_mem_raddr = w_in_idx;
                if (w_in_accept) begin
                    n_op  = t_op'(i_operation);
                    n_idx = w_in_idx;
                    if (w_in_range) begin
                        n_fault = FAULT_OK;
                        n_state = ST_UPDATE;
                    end else begin
                        n_fault = FAULT_RANGE;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_UPDATE: begin
                // Prefetch the first scan entry in the direction that may be needed.
                w_mem_raddr = (r_idx == r_lo) ? r_idx + 1'b1 : r_idx - 1'b1;
                n_state     = ST_FINISH;
                if (r_op == OP_INSERT) begin
                    if (w_mem_rdata == COUNT_MAX) begin
                        n_fault = FAULT_FULL;
                    end else begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = w_mem_rdata + 1'b1;
                        n_total     = r_total + 1'b1;
                        if (r_total == '0) begin
                            n_lo = r_idx;
                            n_hi = r_idx;
                        end else begin
                            if (r_idx < r_lo) begin
                                n_lo = r_idx;
                            end
                            if (r_idx > r_hi) begin
                                n_hi = r_idx;
                            end
                        end
                    end
                end else begin
                    if (w_mem_rdata == '0) begin
                        n_fault = FAULT_ABSENT;
                    end else begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = w_mem_rdata - 1'b1;
                        n_total     = r_total - 1'b1;
                        if (r_total == TOTAL_ONE) begin
                            n_lo = '0;
                            n_hi = '0;
                        end else if (w_mem_rdata == COUNT_ONE) begin
                            // An emptied extreme: the other extreme is still occupied,
                            // so the two cannot coincide here.
                            if (r_idx == r_lo) begin
                                n_ptr   = r_idx + 1'b1;
                                n_state = ST_SCAN_UP;
                            end else if (r_idx == r_hi) begin
                                n_ptr   = r_idx - 1'b1;
                                n_state = ST_SCAN_DN;
                            end
                        end
                    end
                end
            end
            ST_SCAN_UP: begin
                // Data for r_ptr is here; fetch the next entry up.
                w_mem_raddr = r_ptr + 1'b1;
                if ((r_ptr == LAST_IDX) || (w_mem_rdata != '0)) begin
                    n_lo    = r_ptr;
                    n_state = ST_FINISH;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_SCAN_DN: begin
                w_mem_raddr = r_ptr - 1'b1;
                if ((r_ptr == '0) || (w_mem_rdata != '0)) begin
                    n_hi    = r_ptr;
                    n_state = ST_FINISH;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free, then load the result.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_fault = r_fault;
                    if (r_total == '0) begin
                        n_out_low   = '0;
                        n_out_high  = '0;
                        n_out_empty = 1'b1;
                    end else begin
                        n_out_low   = r_range_low + $signed(VALUE_W'(r_lo));
                        n_out_high  = r_range_low + $signed(VALUE_W'(r_hi));
                        n_out_empty = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        // A register write empties the set and restarts the clearing pass.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RANGE_LOW: begin
                    n_range_low = $signed(i_cfg_data);
                end
                CFG_RANGE_HIGH: begin
                    n_range_high = $signed(i_cfg_data);
                end
                default: begin
                    n_range_low = r_range_low;
                end
            endcase
            n_lo      = '0;
            n_hi      = '0;
            n_total   = '0;
            n_clr_ptr = '0;
            n_state   = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_ptr    <= '0;
            r_range_low  <= VALUE_W'(0);
            r_range_high <= VALUE_W'(1023);
            r_lo         <= '0;
            r_hi         <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_ptr    <= n_clr_ptr;
            r_range_low  <= n_range_low;
            r_range_high <= n_range_high;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_ptr       <= n_ptr;
        r_op        <= n_op;
        r_fault     <= n_fault;
        r_out_low   <= n_out_low;
        r_out_high  <= n_out_high;
        r_out_empty <= n_out_empty;
        r_out_fault <= n_out_fault;
    end

    assign o_out_valid  = r_out_valid;
    assign o_low_value  = r_out_low;
    assign o_high_value = r_out_high;
    assign o_set_empty  = r_out_empty;
    assign o_fault      = r_out_fault;

    // Extremes stay ordered whenever the core is idle and the set holds something.
    `CMMM_ASSERT_IMPLY(a_extremes_ordered, i_clk, i_rst_n,
        (r_state == ST_IDLE) && (r_total != '0), r_lo <= r_hi)
    // A non-empty result never reports low above high.
    `CMMM_ASSERT_IMPLY(a_result_ordered, i_clk, i_rst_n,
        r_out_valid && !r_out_empty, r_out_low <= r_out_high)
    // A register write always restarts the clearing pass.
    `CMMM_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n,
        i_cfg_we, (r_state == ST_CLEAR) && (r_total == '0))

endmodule
